// ===== hw/rtl/mm3_pkg.sv =====
// Shared types, constants and helper functions for the MurmurHash3 stream hasher.
// No dependencies; imported by every module of the block.
package mm3_pkg;

	localparam logic [31:0] C1      = 32'hcc9e2d51;
	localparam logic [31:0] C2      = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] F1      = 32'h85ebca6b;
	localparam logic [31:0] F2      = 32'hc2b2ae35;

	localparam logic [2:0] NB_NONE  = 3'd0;
	localparam logic [2:0] NB_ONE   = 3'd1;
	localparam logic [2:0] NB_TWO   = 3'd2;
	localparam logic [2:0] NB_THREE = 3'd3;
	localparam logic [2:0] NB_FULL  = 3'd4;

	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  nb;
		logic        last;
	} blk_t;

	function automatic logic [31:0] byte_mask(input logic [2:0] nb);
		logic [31:0] m;
		case (nb)
			NB_NONE:  m = 32'h0000_0000;
			NB_ONE:   m = 32'h0000_00ff;
			NB_TWO:   m = 32'h0000_ffff;
			NB_THREE: m = 32'h00ff_ffff;
			default:  m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

endpackage

// ===== hw/rtl/mm3_front.sv =====
// Front end: accepts key words, resolves the byte count and masks the tail,
// then scrambles each block over two multiplier stages. Depends on mm3_pkg.
module mm3_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
	input  logic          s_tlast,
	output logic          q_valid,
	input  logic          q_ready,
	output mm3_pkg::blk_t q_data
);
	import mm3_pkg::*;

	logic        v_s1, v_s2;
	logic [31:0] p_s1;
	logic [2:0]  nb_s1;
	logic        last_s1;
	blk_t        blk_s2;
	logic        adv1, adv2, s_fire;
	logic [2:0]  nb_in;
	logic [31:0] word_in;

	assign adv2     = !v_s2 || q_ready;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		if (!s_tlast || s_tdata[34:32] > NB_FULL) begin
			nb_in = NB_FULL;
		end else begin
			nb_in = s_tdata[34:32];
		end
		word_in = s_tdata[31:0] & byte_mask(nb_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_fire;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_fire) begin
			p_s1    <= word_in * C1;
			nb_s1   <= nb_in;
			last_s1 <= s_tlast;
		end
		if (adv2 && v_s1) begin
			blk_s2.k    <= rotl15(p_s1) * C2;
			blk_s2.nb   <= nb_s1;
			blk_s2.last <= last_s1;
		end
	end

	assign q_valid = v_s2;
	assign q_data  = blk_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && !q_ready))
		else $error("front stalled with room in the pipeline");
	a_nb_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (blk_s2.nb <= NB_FULL))
		else $error("byte count above four");
	a_nonlast_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !blk_s2.last) |-> (blk_s2.nb == NB_FULL))
		else $error("inner block not full");
`endif

endmodule

// ===== hw/rtl/mm3_fifo.sv =====
// Small queue that decouples the scramble front end from the hash back end.
// Depends on mm3_pkg for the entry type.
module mm3_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mm3_pkg::blk_t push_data,
	output logic          full,
	input  logic          pop,
	output mm3_pkg::blk_t pop_data,
	output logic          not_empty
);
	import mm3_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	blk_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count overflow");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a push");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !do_pop)
		else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/mm3_back.sv =====
// Back end: folds scrambled blocks into the running hash, appends the length,
// runs the final avalanche and holds the result. Depends on mm3_pkg.
module mm3_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seed_we,
	input  logic [31:0]   seed_wdata,
	input  logic          q_valid,
	output logic          q_pop,
	input  mm3_pkg::blk_t q_data,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata    // [31:0] hash, [63:32] total_length
);
	import mm3_pkg::*;

	typedef enum logic [3:0] {
		ST_ABSORB = 4'b0001,
		ST_FIN1   = 4'b0010,
		ST_FIN2   = 4'b0100,
		ST_FIN3   = 4'b1000
	} state_t;

	state_t      state_q;
	logic [31:0] seed_q, hash_q, count_q, fin_q, len_q;
	logic        in_string_q, out_v_q;
	logic [63:0] out_q;
	logic [31:0] h0, c0, hx, hr, hm, hb, cnt, hl, hf, f2_in;
	logic        out_free;

	assign q_pop    = (state_q == ST_ABSORB) && q_valid;
	assign out_free = !out_v_q || m_tready;

	always_comb begin
		h0    = in_string_q ? hash_q : seed_q;
		c0    = in_string_q ? count_q : 32'd0;
		hx    = h0 ^ q_data.k;
		hr    = rotl13(hx);
		hm    = (hr << 2) + hr + MIX_ADD;
		hb    = (q_data.nb == NB_FULL) ? hm : hx;
		cnt   = c0 + {29'd0, q_data.nb};
		hl    = hb ^ cnt;
		hf    = hl ^ (hl >> 16);
		f2_in = fin_q ^ (fin_q >> 13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ABSORB;
			seed_q      <= 32'd0;
			in_string_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_ABSORB: begin
					if (q_pop) begin
						in_string_q <= !q_data.last;
						if (q_data.last) begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_FIN3;
				ST_FIN3: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= ST_ABSORB;
					end
				end
				default: state_q <= ST_ABSORB;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ABSORB: begin
				if (q_pop) begin
					if (q_data.last) begin
						fin_q <= hf;
						len_q <= cnt;
					end else begin
						hash_q  <= hm;
						count_q <= cnt;
					end
				end
			end
			ST_FIN1: fin_q <= fin_q * F1;
			ST_FIN2: fin_q <= f2_in * F2;
			ST_FIN3: begin
				if (out_free) begin
					out_q <= {len_q, fin_q ^ (fin_q >> 16)};
				end
			end
			default: fin_q <= fin_q;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_pop_absorb: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_ABSORB))
		else $error("queue popped outside absorb");
	a_finish_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN1) |=> (state_q == ST_FIN2))
		else $error("finish sequence broken");
	a_last_ends_string: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_data.last) |=> (!in_string_q && state_q == ST_FIN1))
		else $error("last word did not close the string");
	a_result_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN3 && out_free) |=> out_v_q)
		else $error("finished hash not presented");
`endif

endmodule

// ===== hw/rtl/murmur3_32_stream_hash.sv =====
// Streaming MurmurHash3 x86_32: front scramble pipeline, queue, back-end hash fold.
// Path of a last word: the accepting edge loads scramble stage 1, then scramble stage 2, the
// queue, the fold and the avalanche/output states FIN1, FIN2 and FIN3 follow in that order.
// Throughput: one word per cycle for inner words unless the queue or fold unit stalls; a last
// word holds it in FIN1-FIN3. Reset (arst_n low) clears seed to 0, drops any partial string.
module murmur3_32_stream_hash #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // [31:0] hash, [63:32] total_length
);
	import mm3_pkg::*;

	blk_t f_data, b_data;
	logic f_valid, f_full, b_pop, b_valid;

	mm3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (f_valid),
		.q_ready  (!f_full),
		.q_data   (f_data)
	);

	mm3_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_data (f_data),
		.full      (f_full),
		.pop       (b_pop),
		.pop_data  (b_data),
		.not_empty (b_valid)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.q_valid    (b_valid),
		.q_pop      (b_pop),
		.q_data     (b_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
